### design/pfgw_pkg.sv
// Shared types and constants of the potential field gradient walker.
package pfgw_pkg;

   // Request kinds carried on req_tuser.
   localparam logic [1:0] REQ_LOAD_POT   = 2'd0;
   localparam logic [1:0] REQ_WRITE_PERT = 2'd1;
   localparam logic [1:0] REQ_CLEAR_PERT = 2'd2;
   localparam logic [1:0] REQ_PLAN       = 2'd3;

   // Plan status codes carried on rsp_tuser.
   localparam logic [1:0] STATUS_FULL  = 2'd0;
   localparam logic [1:0] STATUS_EARLY = 2'd1;
   localparam logic [1:0] STATUS_GOAL  = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] REG_ROWS      = 2'd0;
   localparam logic [1:0] REG_COLS      = 2'd1;
   localparam logic [1:0] REG_THRESHOLD = 2'd2;
   localparam logic [1:0] REG_LOOKAHEAD = 2'd3;

   // Neighbour visiting order.
   localparam logic [1:0] DIR_UP    = 2'd0;
   localparam logic [1:0] DIR_DOWN  = 2'd1;
   localparam logic [1:0] DIR_LEFT  = 2'd2;
   localparam logic [1:0] DIR_RIGHT = 2'd3;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_GOAL_RD,
      ST_GOAL_CHK,
      ST_NB_RD,
      ST_NB_EVAL,
      ST_STEP_END,
      ST_FIN_RD,
      ST_DONE
   } state_type;

   // Write strobes toward the grid memories.
   typedef struct packed {
      logic pot_we;
      logic pert_we;
      logic pert_zero;
   } mem_ctl_type;

endpackage

### design/pfgw_grid_mem.sv
// Potential and perturbation grid memories with one write and one registered read port.
module pfgw_grid_mem
   import pfgw_pkg::*;
#(
   parameter int ADDR_BITS  = 16,
   parameter int VALUE_BITS = 32
) (
   input  logic                  clock,
   input  mem_ctl_type           ctl,
   input  logic [ADDR_BITS-1:0]  wr_addr,
   input  logic [VALUE_BITS-1:0] wr_data,
   input  logic [ADDR_BITS-1:0]  rd_addr,
   output logic [VALUE_BITS-1:0] pot_rd,
   output logic [VALUE_BITS-1:0] pert_rd
);

   localparam int DEPTH = 1 << ADDR_BITS;

   logic [VALUE_BITS-1:0] pot_mem  [DEPTH];
   logic [VALUE_BITS-1:0] pert_mem [DEPTH];
   logic [VALUE_BITS-1:0] pot_rd_ff;
   logic [VALUE_BITS-1:0] pert_rd_ff;

   always_ff @(posedge clock) begin
      if (ctl.pot_we) begin
         pot_mem[wr_addr] <= wr_data;
      end
      pot_rd_ff <= pot_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (ctl.pert_zero) begin
         pert_mem[wr_addr] <= '0;
      end else if (ctl.pert_we) begin
         pert_mem[wr_addr] <= wr_data;
      end
      pert_rd_ff <= pert_mem[rd_addr];
   end

   assign pot_rd  = pot_rd_ff;
   assign pert_rd = pert_rd_ff;

endmodule

### design/potential_field_gradient_walker_top.sv
// Top level of the potential field gradient walker: request decode, plan sequencer, CSRs.
//
// The walker holds a static potential grid and a perturbation grid in on-chip memory and
// answers plan requests by greedy 4-neighbour ascent from a start cell. Load and perturbation
// write requests give no response. A clear request, and also the release of reset, starts a
// clearing pass over all MAX_ROWS*MAX_COLS cells of the perturbation grid (65536 with default
// parameters) during which req_tready is low; CSR writes are still taken then. A plan request
// is worked by a small sequencer around one shared read port and one adder/comparator: it
// reads and tests the start cell, then per greedy step reads and evaluates every in-grid
// neighbour and commits the move to the best one, or stops early if none qualifies, and
// finally reads the waypoint potential. The response waits in an output register, so the
// next request is accepted while it is still pending; a following plan holds in its last
// state until that register is free. Only one request is in work at a time.
module potential_field_gradient_walker_top
   import pfgw_pkg::*;
#(
   parameter int MAX_ROWS   = 256,
   parameter int MAX_COLS   = 256,
   parameter int VALUE_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // cell_row[15:0], cell_col[31:16], cell_value[63:32]
   input  logic [1:0]  req_tuser,   // req_type[1:0]
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // waypoint_row[7:0], waypoint_col[15:8],
                                    // steps_taken[21:16], waypoint_potential[53:22], zero
   output logic [1:0]  rsp_tuser,   // plan_status[1:0]
   // CSR port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int ROW_BITS  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int COL_BITS  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int ADDR_BITS = $clog2(MAX_ROWS * MAX_COLS);
   localparam int CELLS     = MAX_ROWS * MAX_COLS;
   localparam int RNB       = ($clog2(MAX_ROWS + 1) > 15) ? $clog2(MAX_ROWS + 1) : 15;
   localparam int CNB       = ($clog2(MAX_COLS + 1) > 15) ? $clog2(MAX_COLS + 1) : 15;
   localparam int WIDE      = (VALUE_BITS > 32) ? VALUE_BITS : 32;
   localparam int SUM_BITS  = VALUE_BITS + 1;

   localparam logic [RNB-1:0]       ROWS_MAX  = RNB'(MAX_ROWS);
   localparam logic [CNB-1:0]       COLS_MAX  = CNB'(MAX_COLS);
   localparam logic [ADDR_BITS-1:0] COLS_K    = ADDR_BITS'(MAX_COLS);
   localparam logic [ADDR_BITS-1:0] LAST_CELL = ADDR_BITS'(CELLS - 1);

   // CSRs.
   logic [8:0]  rows_ff, rows_in;
   logic [8:0]  cols_ff, cols_in;
   logic [31:0] thr_ff, thr_in;
   logic [5:0]  look_ff, look_in;

   // Sequencer and walk state.
   state_type             state_ff, state_in;
   logic [ADDR_BITS-1:0]  clr_ff, clr_in;
   logic [ROW_BITS-1:0]   cur_row_ff, cur_row_in;
   logic [COL_BITS-1:0]   cur_col_ff, cur_col_in;
   logic [ROW_BITS-1:0]   best_row_ff, best_row_in;
   logic [COL_BITS-1:0]   best_col_ff, best_col_in;
   logic [SUM_BITS-1:0]   best_sum_ff, best_sum_in;
   logic                  found_ff, found_in;
   logic [1:0]            dir_ff, dir_in;
   logic [5:0]            steps_ff, steps_in;
   logic [1:0]            status_ff, status_in;

   // Response register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [55:0]           rsp_data_ff, rsp_data_in;
   logic [1:0]            rsp_user_ff, rsp_user_in;

   // Request fields.
   logic [1:0]            req_type;
   logic [15:0]           cell_row;
   logic [15:0]           cell_col;
   logic [31:0]           cell_value;
   logic                  accept;

   // Grid geometry from the CSRs, with out-of-range sizes folded into range.
   logic [RNB-1:0]        nrows;
   logic [CNB-1:0]        ncols;
   logic [ROW_BITS-1:0]   last_row;
   logic [COL_BITS-1:0]   last_col;
   logic                  row_in_grid;
   logic                  col_in_grid;
   logic [ROW_BITS-1:0]   start_row;
   logic [COL_BITS-1:0]   start_col;

   // Neighbour under test.
   logic [ROW_BITS-1:0]   nb_row;
   logic [COL_BITS-1:0]   nb_col;
   logic                  nb_ok;

   // Memory interface.
   mem_ctl_type           mem_ctl;
   logic [ADDR_BITS-1:0]  wr_addr;
   logic [VALUE_BITS-1:0] wr_data;
   logic [ADDR_BITS-1:0]  rd_addr;
   logic [VALUE_BITS-1:0] pot_rd;
   logic [VALUE_BITS-1:0] pert_rd;

   // Shared arithmetic.
   logic [SUM_BITS-1:0]   nb_sum;
   logic                  nb_better;
   logic                  at_goal;
   logic [WIDE-1:0]       pot_wide;
   logic                  csr_write;

   function automatic logic [ADDR_BITS-1:0] cell_addr(input logic [ROW_BITS-1:0] r,
                                                      input logic [COL_BITS-1:0] c);
      cell_addr = ADDR_BITS'(r) * COLS_K + ADDR_BITS'(c);
   endfunction

   assign req_type   = req_tuser;
   assign cell_row   = req_tdata[15:0];
   assign cell_col   = req_tdata[31:16];
   assign cell_value = req_tdata[63:32];
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   assign nrows = (rows_ff == 9'd0) ? RNB'(1)
                : ((RNB'(rows_ff) > ROWS_MAX) ? ROWS_MAX : RNB'(rows_ff));
   assign ncols = (cols_ff == 9'd0) ? CNB'(1)
                : ((CNB'(cols_ff) > COLS_MAX) ? COLS_MAX : CNB'(cols_ff));
   assign last_row = ROW_BITS'(nrows - RNB'(1));
   assign last_col = COL_BITS'(ncols - CNB'(1));

   assign row_in_grid = !cell_row[15] && (RNB'(cell_row[14:0]) < nrows);
   assign col_in_grid = !cell_col[15] && (CNB'(cell_col[14:0]) < ncols);
   assign start_row = cell_row[15] ? '0 : (row_in_grid ? ROW_BITS'(cell_row[14:0]) : last_row);
   assign start_col = cell_col[15] ? '0 : (col_in_grid ? COL_BITS'(cell_col[14:0]) : last_col);

   always_comb begin
      nb_row = cur_row_ff;
      nb_col = cur_col_ff;
      nb_ok  = 1'b0;
      case (dir_ff)
         DIR_UP: begin
            nb_row = cur_row_ff - ROW_BITS'(1);
            nb_ok  = (cur_row_ff != '0);
         end
         DIR_DOWN: begin
            nb_row = cur_row_ff + ROW_BITS'(1);
            nb_ok  = (cur_row_ff != last_row);
         end
         DIR_LEFT: begin
            nb_col = cur_col_ff - COL_BITS'(1);
            nb_ok  = (cur_col_ff != '0);
         end
         DIR_RIGHT: begin
            nb_col = cur_col_ff + COL_BITS'(1);
            nb_ok  = (cur_col_ff != last_col);
         end
         default: begin
            nb_ok = 1'b0;
         end
      endcase
   end

   // One adder and one comparator serve every neighbour of every step.
   assign nb_sum    = SUM_BITS'($signed(pot_rd)) + SUM_BITS'($signed(pert_rd));
   assign nb_better = (pot_rd != '0) && (nb_sum != '0)
                      && (!found_ff || ($signed(nb_sum) > $signed(best_sum_ff)));
   assign pot_wide  = WIDE'($signed(pot_rd));
   assign at_goal   = $signed(pot_wide) >= $signed(WIDE'($signed(thr_ff)));

   pfgw_grid_mem #(
      .ADDR_BITS  (ADDR_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_mem (
      .clock   (clock),
      .ctl     (mem_ctl),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .pot_rd  (pot_rd),
      .pert_rd (pert_rd)
   );

   assign wr_data = VALUE_BITS'($signed(cell_value));
   assign wr_addr = (state_ff == ST_CLEAR) ? clr_ff
                  : cell_addr(ROW_BITS'(cell_row[14:0]), COL_BITS'(cell_col[14:0]));
   assign rd_addr = ((state_ff == ST_NB_RD) || (state_ff == ST_NB_EVAL))
                  ? cell_addr(nb_row, nb_col) : cell_addr(cur_row_ff, cur_col_ff);

   always_comb begin
      mem_ctl.pert_zero = (state_ff == ST_CLEAR);
      mem_ctl.pot_we    = accept && (req_type == REQ_LOAD_POT) && row_in_grid && col_in_grid;
      mem_ctl.pert_we   = accept && (req_type == REQ_WRITE_PERT) && row_in_grid && col_in_grid;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == LAST_CELL) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept && (req_type == REQ_CLEAR_PERT)) begin
               state_in = ST_CLEAR;
            end else if (accept && (req_type == REQ_PLAN)) begin
               state_in = ST_GOAL_RD;
            end
         end
         ST_GOAL_RD: begin
            state_in = ST_GOAL_CHK;
         end
         ST_GOAL_CHK: begin
            if (at_goal || (look_ff == 6'd0)) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_NB_RD;
            end
         end
         ST_NB_RD: begin
            if (nb_ok) begin
               state_in = ST_NB_EVAL;
            end else if (dir_ff == DIR_RIGHT) begin
               state_in = ST_STEP_END;
            end
         end
         ST_NB_EVAL: begin
            state_in = (dir_ff == DIR_RIGHT) ? ST_STEP_END : ST_NB_RD;
         end
         ST_STEP_END: begin
            if (!found_ff || ((steps_ff + 6'd1) == look_ff)) begin
               state_in = ST_FIN_RD;
            end else begin
               state_in = ST_NB_RD;
            end
         end
         ST_FIN_RD: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Walk datapath and response register.
   always_comb begin
      clr_in       = clr_ff;
      cur_row_in   = cur_row_ff;
      cur_col_in   = cur_col_ff;
      best_row_in  = best_row_ff;
      best_col_in  = best_col_ff;
      best_sum_in  = best_sum_ff;
      found_in     = found_ff;
      dir_in       = dir_ff;
      steps_in     = steps_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + ADDR_BITS'(1);
         end
         ST_IDLE: begin
            clr_in = '0;
            if (accept && (req_type == REQ_PLAN)) begin
               cur_row_in  = start_row;
               cur_col_in  = start_col;
               steps_in    = '0;
               best_sum_in = '0;
               status_in   = STATUS_FULL;
            end
         end
         ST_GOAL_CHK: begin
            dir_in   = DIR_UP;
            found_in = 1'b0;
            if (at_goal) begin
               status_in = STATUS_GOAL;
            end
         end
         ST_NB_RD: begin
            if (!nb_ok && (dir_ff != DIR_RIGHT)) begin
               dir_in = dir_ff + 2'd1;
            end
         end
         ST_NB_EVAL: begin
            if (nb_better) begin
               found_in    = 1'b1;
               best_sum_in = nb_sum;
               best_row_in = nb_row;
               best_col_in = nb_col;
            end
            dir_in = dir_ff + 2'd1;
         end
         ST_STEP_END: begin
            dir_in   = DIR_UP;
            found_in = 1'b0;
            if (found_ff) begin
               cur_row_in = best_row_ff;
               cur_col_in = best_col_ff;
               steps_in   = steps_ff + 6'd1;
            end else begin
               status_in = STATUS_EARLY;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = status_ff;
               rsp_data_in  = {2'b00, pot_wide[31:0], steps_ff, 8'(cur_col_ff), 8'(cur_row_ff)};
            end
         end
         default: begin
            clr_in = clr_ff;
         end
      endcase
   end

   // CSRs.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      thr_in  = thr_ff;
      look_in = look_ff;
      if (csr_write) begin
         case (csr_paddr[3:2])
            REG_ROWS:      rows_in = csr_pwdata[8:0];
            REG_COLS:      cols_in = csr_pwdata[8:0];
            REG_THRESHOLD: thr_in  = csr_pwdata;
            REG_LOOKAHEAD: look_in = csr_pwdata[5:0];
            default:       rows_in = rows_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_ROWS:      csr_prdata = {23'd0, rows_ff};
         REG_COLS:      csr_prdata = {23'd0, cols_ff};
         REG_THRESHOLD: csr_prdata = thr_ff;
         REG_LOOKAHEAD: csr_prdata = {26'd0, look_ff};
         default:       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         rows_ff      <= 9'd256;
         cols_ff      <= 9'd256;
         thr_ff       <= 32'd6553600;
         look_ff      <= 6'd6;
         found_ff     <= 1'b0;
         dir_ff       <= DIR_UP;
         steps_ff     <= '0;
         status_ff    <= STATUS_FULL;
         cur_row_ff   <= '0;
         cur_col_ff   <= '0;
         best_sum_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
         thr_ff       <= thr_in;
         look_ff      <= look_in;
         found_ff     <= found_in;
         dir_ff       <= dir_in;
         steps_ff     <= steps_in;
         status_ff    <= status_in;
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
         best_sum_ff  <= best_sum_in;
      end
   end

   always_ff @(posedge clock) begin
      best_row_ff <= best_row_in;
      best_col_ff <= best_col_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // A walk never counts more moves than the lookahead allows.
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff != ST_IDLE) && (state_ff != ST_CLEAR) && (state_ff != ST_GOAL_RD))
      |-> (steps_ff <= look_ff))
      else $error("walk step count passed the lookahead");

   // A goal response reports no moves.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == STATUS_GOAL)) |-> (rsp_tdata[21:16] == 6'd0))
      else $error("goal response with nonzero step count");

   // Status codes above goal are never produced.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser != 2'd3))
      else $error("undefined plan status");

   // The clearing pass after reset keeps requests out.
   assert property (@(posedge clock) $fell(reset) |-> !req_tready)
      else $error("request accepted before the perturbation grid was cleared");

endmodule

### test/tb_potential_field_gradient_walker_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the potential field gradient walker top level.
module tb_potential_field_gradient_walker_top
   import pfgw_pkg::*;
();

   localparam int GRID_SIDE = 256;
   localparam int GRID_CELLS = GRID_SIDE * GRID_SIDE;
   // Longest plan the sequencer can take, plus margin for the output register.
   localparam int SETTLE_CYCLES = 4 + 9 * 63 + 64;

   // One plan response as it travels on the response channel.
   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  row;
      logic [7:0]  col;
      logic [5:0]  steps;
      logic [31:0] potential;
   } plan_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;    // cell_row[15:0], cell_col[31:16], cell_value[63:32]
   logic [1:0]  req_tuser = '0;    // req_type[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;         // waypoint_row[7:0], waypoint_col[15:8],
                                   // steps_taken[21:16], waypoint_potential[53:22], zero
   logic [1:0]  rsp_tuser;         // plan_status[1:0]
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   potential_field_gradient_walker_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready)
   );

   // The testbench's own copy of the grids, the registers and the pending plans.
   logic signed [31:0] potential_grid[GRID_CELLS];
   logic signed [31:0] perturbation_grid[GRID_CELLS];
   bit                 cell_loaded[GRID_CELLS];
   int                 rows_reg = 256;
   int                 cols_reg = 256;
   logic signed [31:0] goal_reg = 32'sd6553600;
   int                 lookahead_reg = 6;
   plan_result_type    pending_plans[$];

   int  failures = 0;
   int  requests_sent = 0;
   int  plans_checked = 0;
   int  status_seen[3] = '{0, 0, 0};
   int  burst_left = 0;
   bit  gaps_on = 1'b1;
   bit  [9:0] stall_phase = '0;

   initial begin
      forever #5 clock = ~clock;
   end

   // Generous ceiling on the whole run; a correct run ends far sooner.
   initial begin
      #60_000_000;
      $display("** potential_field_gradient_walker_top: FAILED **");
      $finish;
   end

   function automatic int grid_rows();
      return (rows_reg < 1) ? 1 : (rows_reg > GRID_SIDE) ? GRID_SIDE : rows_reg;
   endfunction

   function automatic int grid_cols();
      return (cols_reg < 1) ? 1 : (cols_reg > GRID_SIDE) ? GRID_SIDE : cols_reg;
   endfunction

   // Applies one accepted request to the grid copy and, for a plan, walks the
   // greedy ascent and queues the response it must produce.
   function automatic void apply_request(logic [1:0] kind, logic [15:0] row_in,
                                         logic [15:0] col_in, logic [31:0] value);
      int r, c, nr, nc, tr, tc, br, bc, k, i, steps;
      logic [1:0] status;
      logic signed [32:0] sum, best;
      bit found;
      r = $signed(row_in);
      c = $signed(col_in);
      nr = grid_rows();
      nc = grid_cols();
      case (kind)
         REQ_LOAD_POT, REQ_WRITE_PERT: begin
            if (r >= 0 && r < nr && c >= 0 && c < nc) begin
               if (kind == REQ_LOAD_POT) begin
                  potential_grid[r * GRID_SIDE + c] = value;
                  cell_loaded[r * GRID_SIDE + c] = 1'b1;
               end else begin
                  perturbation_grid[r * GRID_SIDE + c] = value;
               end
            end
         end
         REQ_CLEAR_PERT: begin
            foreach (perturbation_grid[j]) perturbation_grid[j] = '0;
         end
         default: begin
            if (r < 0) r = 0;
            if (r > nr - 1) r = nr - 1;
            if (c < 0) c = 0;
            if (c > nc - 1) c = nc - 1;
            steps = 0;
            status = STATUS_FULL;
            if (potential_grid[r * GRID_SIDE + c] >= goal_reg) begin
               status = STATUS_GOAL;
            end else begin
               for (i = 0; i < lookahead_reg; i++) begin
                  found = 1'b0;
                  best = '0;
                  br = 0;
                  bc = 0;
                  for (k = 0; k < 4; k++) begin
                     tr = r + ((k == DIR_UP) ? -1 : (k == DIR_DOWN) ? 1 : 0);
                     tc = c + ((k == DIR_LEFT) ? -1 : (k == DIR_RIGHT) ? 1 : 0);
                     if (tr < 0 || tr >= nr || tc < 0 || tc >= nc) continue;
                     sum = $signed({potential_grid[tr * GRID_SIDE + tc][31],
                                    potential_grid[tr * GRID_SIDE + tc]})
                         + $signed({perturbation_grid[tr * GRID_SIDE + tc][31],
                                    perturbation_grid[tr * GRID_SIDE + tc]});
                     if (potential_grid[tr * GRID_SIDE + tc] == 0 || sum == 0) continue;
                     if (!found || sum > best) begin
                        found = 1'b1;
                        best = sum;
                        br = tr;
                        bc = tc;
                     end
                  end
                  if (!found) begin
                     status = STATUS_EARLY;
                     break;
                  end
                  r = br;
                  c = bc;
                  steps++;
               end
            end
            pending_plans.push_back('{status, r[7:0], c[7:0], steps[5:0],
                                      potential_grid[r * GRID_SIDE + c]});
         end
      endcase
   endfunction

   // Potential and perturbation values: mostly small positive Q16.16 numbers so
   // that walks go somewhere, plus zeros, ties, negatives and the extremes.
   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return '0;
         1, 2, 3: return 32'($urandom_range(1, 300)) << 16;
         4:       return 32'($urandom_range(1, 4)) << 16;
         5:       return -(32'($urandom_range(1, 300)) << 16);
         6:       return $urandom;
         7:       return 32'($urandom_range(0, 32)) - 32'd16;
         8:       return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
         default: return 32'($urandom_range(1, 65535));
      endcase
   endfunction

   // Sends one request: when gaps are on, the sender idles between bursts of random length.
   task automatic send_request(logic [1:0] kind, logic [15:0] row, logic [15:0] col,
                               logic [31:0] value);
      if (gaps_on && burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      if (burst_left > 0) burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {value, col, row};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      apply_request(kind, row, col, value);
      requests_sent++;
   endtask

   task automatic stop_requests();
      req_tvalid <= 1'b0;
   endtask

   // A plan must never touch a cell that was never loaded. Every cell the walk
   // could read lies within lookahead+1 moves of the clamped start, so those
   // cells are loaded first where needed.
   task automatic plan_from(logic [15:0] row, logic [15:0] col);
      int sr, sc, span, r, c, reach;
      sr = $signed(row);
      sc = $signed(col);
      sr = (sr < 0) ? 0 : (sr > grid_rows() - 1) ? grid_rows() - 1 : sr;
      sc = (sc < 0) ? 0 : (sc > grid_cols() - 1) ? grid_cols() - 1 : sc;
      span = lookahead_reg + 1;
      for (r = sr - span; r <= sr + span; r++) begin
         for (c = sc - span; c <= sc + span; c++) begin
            reach = ((r > sr) ? r - sr : sr - r) + ((c > sc) ? c - sc : sc - c);
            if (r < 0 || r >= grid_rows() || c < 0 || c >= grid_cols() || reach > span)
               continue;
            if (!cell_loaded[r * GRID_SIDE + c])
               send_request(REQ_LOAD_POT, 16'(r), 16'(c), pick_value());
         end
      end
      send_request(REQ_PLAN, row, col, $urandom);
   endtask

   // The block is idle once every plan has answered, the clearing pass is over
   // and the sequencer has had time to finish any trailing work.
   task automatic wait_idle();
      stop_requests();
      @(posedge clock);
      while (pending_plans.size() != 0 || !req_tready) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes one register, reads it back and updates the local copy.
   task automatic write_register(logic [1:0] index, logic [31:0] data);
      logic [31:0] mask;
      logic [31:0] readback;
      mask = (index == REG_THRESHOLD) ? 32'hffff_ffff :
             (index == REG_LOOKAHEAD) ? 32'h0000_003f : 32'h0000_01ff;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      readback = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      if ((readback & mask) != (data & mask)) begin
         failures++;
         if (failures <= 10)
            $display("register %0d readback: expected %h, got %h", index, data & mask,
                     readback & mask);
      end
      case (index)
         REG_ROWS:      rows_reg = data & 32'h1ff;
         REG_COLS:      cols_reg = data & 32'h1ff;
         REG_THRESHOLD: goal_reg = data;
         default:       lookahead_reg = data & 32'h3f;
      endcase
   endtask

   task automatic configure(int rows, int cols, logic [31:0] threshold, int lookahead);
      wait_idle();
      write_register(REG_ROWS, 32'(rows));
      write_register(REG_COLS, 32'(cols));
      write_register(REG_THRESHOLD, threshold);
      write_register(REG_LOOKAHEAD, 32'(lookahead));
   endtask

   // Receiver readiness: the top two bits of stall_phase pick one of four patterns in turn,
   // one of them never stalling.
   always @(posedge clock) begin
      stall_phase <= stall_phase + 1'b1;
      case (stall_phase[9:8])
         2'd0:    rsp_tready <= 1'b1;
         2'd1:    rsp_tready <= 1'($urandom_range(0, 1));
         2'd2:    rsp_tready <= (stall_phase[2:0] == 3'd0);
         default: rsp_tready <= stall_phase[4];
      endcase
   end

   // Response checker: each accepted response against the oldest pending plan.
   always @(posedge clock) begin
      plan_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tuser, rsp_tdata[7:0], rsp_tdata[15:8], rsp_tdata[21:16],
                 rsp_tdata[53:22]};
         if (pending_plans.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("response with no plan pending: status %0d row %0d col %0d",
                        got.status, got.row, got.col);
         end else begin
            want = pending_plans.pop_front();
            plans_checked++;
            if (want.status <= STATUS_GOAL) status_seen[want.status]++;
            if (got.status != want.status || got.row != want.row || got.col != want.col ||
                got.steps != want.steps || got.potential != want.potential) begin
               failures++;
               if (failures <= 10)
                  $display("plan %0d mismatch: expected st %0d (%0d,%0d) steps %0d pot %h,",
                           plans_checked, want.status, want.row, want.col, want.steps,
                           want.potential,
                           " got st %0d (%0d,%0d) steps %0d pot %h",
                           got.status, got.row, got.col, got.steps, got.potential);
            end
         end
      end
   end

   // Hand-built cases on a 4x4 grid: ascent, ties, goal, early stop, clamping,
   // ignored writes, cancelling perturbations, clearing and zero lookahead.
   task automatic test_directed();
      int r, c;
      configure(4, 4, 32'(100) << 16, 3);
      for (r = 0; r < 4; r++)
         for (c = 0; c < 4; c++)
            send_request(REQ_LOAD_POT, 16'(r), 16'(c), 32'(r * 4 + c + 1) << 16);
      send_request(REQ_LOAD_POT, 16'd1, 16'd0, 32'd5 << 16);      // tie with (0,1)
      send_request(REQ_LOAD_POT, 16'd0, 16'd1, 32'd5 << 16);
      send_request(REQ_LOAD_POT, 16'd3, 16'd3, 32'd200 << 16);    // goal corner
      send_request(REQ_LOAD_POT, 16'd4, 16'd0, 32'h7fff_ffff);    // outside, ignored
      send_request(REQ_WRITE_PERT, 16'hffff, 16'd2, 32'h7fff_ffff);
      send_request(REQ_LOAD_POT, 16'h7fff, 16'h8000, 32'h8000_0000);
      plan_from(16'd0, 16'd0);
      plan_from(16'h7fff, 16'h7fff);                              // clamps onto the goal
      send_request(REQ_WRITE_PERT, 16'd1, 16'd1, -(32'd6 << 16)); // sum cancels to zero
      send_request(REQ_WRITE_PERT, 16'd0, 16'd2, 32'h7fff_ffff);
      send_request(REQ_LOAD_POT, 16'd2, 16'd0, 32'h7fff_ffff);
      plan_from(16'h8000, 16'h8000);
      send_request(REQ_LOAD_POT, 16'd0, 16'd1, '0);               // zero static cell
      send_request(REQ_LOAD_POT, 16'd1, 16'd0, '0);
      plan_from(16'd0, 16'd0);                                    // nowhere to go
      send_request(REQ_CLEAR_PERT, '0, '0, $urandom);
      plan_from(16'd1, 16'd1);
      configure(4, 4, 32'(100) << 16, 0);
      plan_from(16'd2, 16'd1);                                    // zero lookahead
   endtask

   // Grid sizes out of range, the threshold extremes and the longest lookahead.
   task automatic test_register_extremes();
      configure(0, 511, 32'h8000_0000, 2);                        // 1 row, 256 columns
      plan_from(16'd3, 16'd100);
      configure(511, 0, 32'h7fff_ffff, 5);                        // 256 rows, 1 column
      plan_from(16'd200, 16'd9);
      plan_from(16'hfff0, 16'd0);
      configure(256, 256, 32'h7fff_ffff, 4);
      plan_from(16'd255, 16'd255);
      configure(6, 5, 32'h7fff_ffff, 63);
      plan_from(16'd2, 16'd2);
      plan_from(16'd5, 16'd0);
   endtask

   // Random phases, each with its own settings. Large grids keep the lookahead
   // short and plan around a hot spot so the loaded region stays small.
   task automatic test_random_traffic();
      int phase, n, nr, nc, hot_r, hot_c, pick;
      int row_menu[11] = '{0, 1, 2, 3, 5, 8, 13, 20, 256, 511, 0};
      logic [15:0] row, col;
      for (phase = 0; phase < 12; phase++) begin
         row_menu[10] = $urandom_range(1, 256);
         nr = row_menu[$urandom_range(0, 10)];
         nc = row_menu[$urandom_range(0, 10)];
         configure(nr, nc,
                   $urandom_range(0, 3) == 0 ? $urandom : 32'($urandom_range(20, 320)) << 16,
                   0);
         if (grid_rows() * grid_cols() <= 400)
            write_register(REG_LOOKAHEAD, $urandom_range(0, 1) ? 32'($urandom_range(0, 63))
                                                               : 32'd63);
         else
            write_register(REG_LOOKAHEAD, 32'($urandom_range(0, 6)));
         gaps_on = (phase % 3 != 2);
         hot_r = $urandom_range(0, grid_rows() - 1);
         hot_c = $urandom_range(0, grid_cols() - 1);
         if (phase == 4 || phase == 9)
            send_request(REQ_CLEAR_PERT, 16'($urandom), 16'($urandom), $urandom);
         for (n = 0; n < 50; n++) begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 9) == 0) begin
               row = 16'($urandom);
               col = 16'($urandom);
            end else begin
               row = 16'(hot_r + $urandom_range(0, 8) - 4);
               col = 16'(hot_c + $urandom_range(0, 8) - 4);
            end
            if (pick < 50)      send_request(REQ_LOAD_POT, row, col, pick_value());
            else if (pick < 72) send_request(REQ_WRITE_PERT, row, col, pick_value());
            else                plan_from(row, col);
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_register_extremes();
      test_random_traffic();
      wait_idle();
      if (pending_plans.size() != 0) begin
         failures++;
         $display("%0d plans never answered", pending_plans.size());
      end
      $display("Sent %0d requests and checked %0d plans", requests_sent, plans_checked,
               " (%0d full, %0d stopped early, %0d goal).",
               status_seen[0], status_seen[1], status_seen[2]);
      $display("Mismatches: %0d.", failures);
      if (failures == 0) begin
         $display("** potential_field_gradient_walker_top: PASSED **");
      end else begin
         $display("** potential_field_gradient_walker_top: FAILED **");
      end
      $finish;
   end

endmodule

### sim.f
design/pfgw_pkg.sv
design/pfgw_grid_mem.sv
design/potential_field_gradient_walker_top.sv
test/tb_potential_field_gradient_walker_top.sv
